@@ hdl/sfema_pkg.sv @@
package sfema_pkg;

  localparam int Q_BITS     = 16;
  localparam int WEIGHT_W   = 17;
  localparam int WIN_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [WEIGHT_W-1:0] Q_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WEIGHT = 2'd1,
    REG_WINDOW = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_EXP = 1'b0,
    CMD_AVG = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      seg_end;
  } cmd_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP_DIFF,
    ST_EXP_MUL,
    ST_EXP_ACC,
    ST_EXP_OUT,
    ST_AVG_PUSH,
    ST_AVG_CHECK,
    ST_AVG_DIV,
    ST_AVG_WAIT,
    ST_AVG_OUT
  } back_state_t;

  typedef struct packed {
    logic busy;
    logic first_pending;
  } back_status_t;

endpackage

@@ hdl/sfema_ram.sv @@
module sfema_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/sfema_front.sv @@
module sfema_front import sfema_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   segment_end,
  input  logic                   filter_mode,
  output logic                   cmd_valid,
  output cmd_ctl_t               cmd_ctl,
  output logic [SAMPLE_BITS-1:0] cmd_sample,
  input  logic                   cmd_pop
);

  // two-beat command queue
  logic [SAMPLE_BITS-1:0] slot_sample [2];
  cmd_ctl_t               slot_ctl [2];
  logic                   wr_sel;
  logic                   rd_sel;
  logic [1:0]             fill;
  logic                   do_push;
  logic                   do_pop;

  assign full       = fill[1];
  assign cmd_valid  = (fill != 2'd0);
  assign do_push    = push && !full;
  assign do_pop     = cmd_pop && cmd_valid;
  assign cmd_sample = slot_sample[rd_sel];
  assign cmd_ctl    = slot_ctl[rd_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_sel <= ~wr_sel;
      end
      if (do_pop) begin
        rd_sel <= ~rd_sel;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_sample[wr_sel] <= sample;
      slot_ctl[wr_sel]    <= cmd_ctl_t'{kind: (filter_mode ? CMD_AVG : CMD_EXP),
                                        seg_end: segment_end};
    end
  end

endmodule

@@ hdl/sfema_div.sv @@
module sfema_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  // restoring divide on magnitudes, one quotient bit per cycle, truncates toward zero
  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    steps;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic             neg;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;

  assign busy     = (steps != '0);
  assign shifted  = {rem, quo[NUM_W-1]};
  assign trial    = shifted - {1'b0, den};
  assign quotient = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= CW'(NUM_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[NUM_W-1];
      quo <= dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      if (!trial[DEN_W]) begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/sfema_back.sv @@
module sfema_back import sfema_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 64,
  parameter int CNT_W       = $clog2(MAX_WINDOW + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   seg_clear,
  input  logic [WEIGHT_W-1:0]    weight,
  input  logic [CNT_W-1:0]       win,
  input  logic                   cmd_valid,
  input  cmd_ctl_t               cmd_ctl,
  input  logic [SAMPLE_BITS-1:0] cmd_sample,
  output logic                   cmd_pop,
  input  logic                   pop,
  output logic                   empty,
  output logic [SAMPLE_BITS-1:0] smoothed,
  output logic                   run_last,
  output back_status_t           status,
  output logic [CNT_W-1:0]       held_count
);

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int LVL_W  = SAMPLE_BITS + Q_BITS + 1;
  localparam int DIFF_W = LVL_W + 1;
  localparam int DH_W   = DIFF_W - Q_BITS;
  localparam int PH_W   = WEIGHT_W + DH_W;
  localparam int PL_W   = WEIGHT_W + Q_BITS;

  function automatic logic [DIFF_W-1:0] target_of(input logic [SAMPLE_BITS-1:0] x);
    target_of = {{(DIFF_W-SAMPLE_BITS-Q_BITS){x[SAMPLE_BITS-1]}}, x, {Q_BITS{1'b0}}};
  endfunction

  function automatic logic [SUM_W-1:0] sum_ext(input logic [SAMPLE_BITS-1:0] x);
    sum_ext = {{(SUM_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

  back_state_t state, state_next;

  logic                   first_pending;
  logic [CNT_W-1:0]       held;
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [SUM_W-1:0]       wsum;
  logic [LVL_W-1:0]       level;
  logic [SAMPLE_BITS-1:0] x_reg;
  logic                   seg_reg;
  logic [DIFF_W-1:0]      diff;
  logic signed [PH_W-1:0] ph;
  logic [PL_W-1:0]        pl;
  logic [PH_W-1:0]        lvl_sum;
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_value;
  logic                   out_last;

  logic                   go_div;
  logic                   div_start;
  logic                   div_busy;
  logic [SUM_W-1:0]       div_q;
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic                   emit;

  assign empty         = !out_valid;
  assign smoothed      = out_value;
  assign run_last      = out_last;
  assign held_count    = held;
  assign status.busy   = (state != ST_IDLE);
  assign status.first_pending = first_pending;

  // another result is owed: a full window, or a flush on segment end
  assign go_div  = (held >= win) || (seg_reg && (held != '0));
  assign lvl_sum = {{(PH_W-LVL_W){level[LVL_W-1]}}, level} + ph
                 + {{(PH_W-WEIGHT_W){1'b0}}, pl[PL_W-1:Q_BITS]};

  sfema_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_held (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(wr_ptr),
    .wr_data(x_reg),
    .rd_addr(rd_ptr),
    .rd_data(old_sample)
  );

  sfema_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(wsum),
    .divisor (held),
    .busy    (div_busy),
    .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd_ctl.kind == CMD_AVG) begin
            state_next = ST_AVG_PUSH;
          end else if (first_pending) begin
            state_next = ST_EXP_OUT;
          end else begin
            state_next = ST_EXP_DIFF;
          end
        end
      end
      ST_EXP_DIFF:  state_next = ST_EXP_MUL;
      ST_EXP_MUL:   state_next = ST_EXP_ACC;
      ST_EXP_ACC:   state_next = ST_EXP_OUT;
      ST_EXP_OUT: begin
        if (!out_valid) begin
          state_next = ST_IDLE;
        end
      end
      ST_AVG_PUSH:  state_next = ST_AVG_CHECK;
      ST_AVG_CHECK: state_next = go_div ? ST_AVG_DIV : ST_IDLE;
      ST_AVG_DIV:   state_next = ST_AVG_WAIT;
      ST_AVG_WAIT: begin
        if (!div_busy) begin
          state_next = ST_AVG_OUT;
        end
      end
      ST_AVG_OUT: begin
        if (!out_valid) begin
          state_next = ST_AVG_CHECK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    emit      = 1'b0;
    unique case (state)
      ST_IDLE:     cmd_pop   = cmd_valid;
      ST_AVG_PUSH: ram_we    = 1'b1;
      ST_AVG_DIV:  div_start = 1'b1;
      ST_EXP_OUT,
      ST_AVG_OUT:  emit      = !out_valid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_pending <= 1'b1;
      held          <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      wsum          <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end
      if (seg_clear) begin
        first_pending <= 1'b1;
        held          <= '0;
        wr_ptr        <= '0;
        rd_ptr        <= '0;
        wsum          <= '0;
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (cmd_pop && (cmd_ctl.kind == CMD_EXP)) begin
              first_pending <= cmd_ctl.seg_end;
            end
          end
          ST_AVG_PUSH: begin
            wr_ptr <= ptr_inc(wr_ptr);
            held   <= held + 1'b1;
            wsum   <= wsum + sum_ext(x_reg);
          end
          ST_AVG_CHECK: begin
            if (!go_div && seg_reg) begin
              first_pending <= 1'b1;
            end
          end
          ST_AVG_OUT: begin
            if (emit) begin
              rd_ptr <= ptr_inc(rd_ptr);
              held   <= held - 1'b1;
              wsum   <= wsum - sum_ext(old_sample);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      x_reg   <= cmd_sample;
      seg_reg <= cmd_ctl.seg_end;
      if ((cmd_ctl.kind == CMD_EXP) && first_pending) begin
        level <= LVL_W'(target_of(cmd_sample));
      end
    end
    if (state == ST_EXP_DIFF) begin
      diff <= target_of(x_reg) - {level[LVL_W-1], level};
    end
    if (state == ST_EXP_MUL) begin
      ph <= $signed({1'b0, weight}) * $signed(diff[DIFF_W-1:Q_BITS]);
      pl <= weight * diff[Q_BITS-1:0];
    end
    if (state == ST_EXP_ACC) begin
      level <= lvl_sum[LVL_W-1:0];
    end
    if (emit) begin
      if (state == ST_EXP_OUT) begin
        out_value <= level[Q_BITS +: SAMPLE_BITS];
        out_last  <= seg_reg;
      end else begin
        out_value <= div_q[SAMPLE_BITS-1:0];
        out_last  <= seg_reg && (held == CNT_W'(1));
      end
    end
  end

endmodule

@@ hdl/smoothing_filter_exp_or_moving_avg.sv @@
// Smoothing filter, exponential (Q16 weight) or forward moving average over up to
// MAX_WINDOW samples. Input beats enter a two-beat command queue; one result register
// sits on the output. Exponential mode steps: take, difference, a two-part weight
// multiply, accumulate, result; the first sample of a segment goes from take straight
// to result. Moving-average mode: a sample that completes no window is taken, stored
// and checked; each result comes from the one-bit-per-cycle divider, dividing the
// window sum of SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW+1) bits (23 with the defaults)
// by the held count. A result that is not popped holds the back end. A segment-end beat
// flushes one result per held sample, the last one flagged run_last. The sample store
// needs no clearing after reset. Configuration is taken only while the back end is idle
// with no queued beat; writing filter_mode or window_length restarts the segment.
module smoothing_filter_exp_or_moving_avg import sfema_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   segment_end,
  output logic                   empty,
  input  logic                   pop,
  output logic [SAMPLE_BITS-1:0] smoothed,
  output logic                   run_last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  logic                   filter_mode;
  logic [WEIGHT_W-1:0]    smoothing_weight;
  logic [WIN_W-1:0]       window_length;
  logic [WEIGHT_W-1:0]    weight_eff;
  logic [CNT_W-1:0]       win_eff;
  logic                   cfg_fire;
  logic                   seg_clear;

  logic                   cmd_valid;
  cmd_ctl_t               cmd_ctl;
  logic [SAMPLE_BITS-1:0] cmd_sample;
  logic                   cmd_pop;
  back_status_t           status;
  logic [CNT_W-1:0]       held_count;

  assign cfg_ready = !status.busy && !cmd_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign seg_clear = cfg_fire && ((cfg_index == REG_MODE) || (cfg_index == REG_WINDOW));

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode      <= 1'b0;
      smoothing_weight <= WEIGHT_W'(32768);
      window_length    <= WIN_W'(4);
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_MODE:   filter_mode      <= cfg_data[0];
        REG_WEIGHT: smoothing_weight <= cfg_data[WEIGHT_W-1:0];
        REG_WINDOW: window_length    <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign weight_eff = (smoothing_weight > Q_ONE) ? Q_ONE : smoothing_weight;

  always_comb begin
    if (window_length == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(window_length);
    end
  end

  sfema_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample     (sample),
    .segment_end(segment_end),
    .filter_mode(filter_mode),
    .cmd_valid  (cmd_valid),
    .cmd_ctl    (cmd_ctl),
    .cmd_sample (cmd_sample),
    .cmd_pop    (cmd_pop)
  );

  sfema_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .seg_clear (seg_clear),
    .weight    (weight_eff),
    .win       (win_eff),
    .cmd_valid (cmd_valid),
    .cmd_ctl   (cmd_ctl),
    .cmd_sample(cmd_sample),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .smoothed  (smoothed),
    .run_last  (run_last),
    .status    (status),
    .held_count(held_count)
  );

  // restart leaves an empty window and a pending first sample
  a_restart: assert property (@(posedge clk) disable iff (rst)
    seg_clear |=> (held_count == '0) && status.first_pending)
    else $error("segment restart did not clear window state");

  a_held_max: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(MAX_WINDOW))
    else $error("held count above store depth");

  // between beats the window is never full
  a_idle_partial: assert property (@(posedge clk) disable iff (rst)
    (filter_mode && !status.busy) |-> (held_count < win_eff))
    else $error("full window left unserved at idle");

endmodule
